// ===== rtl/lvm_pkg.sv =====
// Shared widths, types and helpers of the log vorticity magnitude unit.
package lvm_pkg;

   // component format: signed, three integer bits, rest fraction
   localparam int COMPONENT_BITS = 16;
   localparam int FRAC_BITS      = COMPONENT_BITS - 3;
   localparam int VEC_BITS       = 48;
   localparam int EXT_BITS       = (3 * COMPONENT_BITS > VEC_BITS) ?
                                   3 * COMPONENT_BITS : VEC_BITS;

   // datapath widths
   localparam int DIFF_BITS = COMPONENT_BITS + 1;
   localparam int CURL_BITS = COMPONENT_BITS + 2;
   localparam int SQ_BITS   = 2 * CURL_BITS;
   localparam int SUM_BITS  = SQ_BITS + 2;
   localparam int EXP_BITS  = $clog2(SUM_BITS);
   localparam int MANT_BITS = 32;
   localparam int NORM_BITS = (SUM_BITS > MANT_BITS) ? SUM_BITS : MANT_BITS;
   localparam int SHIFT_BITS = $clog2(NORM_BITS);

   // log2 in fixed point, then scaled by ln 2
   localparam int LOG_FRAC      = 24;
   localparam int LOG_INT_BITS  = $clog2(2 * COMPONENT_BITS) + 2;
   localparam int LOG_BITS      = LOG_INT_BITS + LOG_FRAC;
   localparam int LOG_OFFSET    = 2 * FRAC_BITS + 2;
   localparam int LN2_FRAC      = 30;
   localparam int LN2_BITS      = 32;
   localparam logic [LN2_BITS-1:0] LN2_Q30 = 32'd744261118;
   localparam int PROD_BITS     = LOG_BITS + LN2_BITS;
   localparam int OUT_FRAC      = 10;
   localparam int ROUND_SHIFT   = LOG_FRAC + LN2_FRAC - OUT_FRAC;
   localparam int MAG_BITS      = PROD_BITS + 1 - ROUND_SHIFT;

   // result format
   localparam int OUT_BITS = 16;
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   // queue sizes
   localparam int MQ_DEPTH = 4;
   localparam int MQ_PTR   = $clog2(MQ_DEPTH);
   localparam int RQ_DEPTH = 32;
   localparam int RQ_PTR   = $clog2(RQ_DEPTH);

   typedef enum logic [1:0] {
      MODE_XY  = 2'd0,
      MODE_XZ  = 2'd1,
      MODE_YZ  = 2'd2,
      MODE_ROT = 2'd3
   } plane_mode_type;

   // one pair difference per velocity component
   typedef struct packed {
      logic signed [DIFF_BITS-1:0] x;
      logic signed [DIFF_BITS-1:0] y;
      logic signed [DIFF_BITS-1:0] z;
   } diff_type;

   // curl components, twice the derivative scale
   typedef struct packed {
      logic signed [CURL_BITS-1:0] c1;
      logic signed [CURL_BITS-1:0] c2;
      logic signed [CURL_BITS-1:0] c3;
   } curl_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] log_vorticity;
      logic                       zero_magnitude;
   } result_type;

   // pull one signed component out of a packed vector
   function automatic logic signed [COMPONENT_BITS-1:0] comp_of(
      input logic [VEC_BITS-1:0] vec,
      input int                  k
   );
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(vec);
      return ext[k * COMPONENT_BITS +: COMPONENT_BITS];
   endfunction

   // difference b - a of two packed vectors, per component
   function automatic diff_type diff_of(
      input logic [VEC_BITS-1:0] a,
      input logic [VEC_BITS-1:0] b
   );
      diff_type d;
      d.x = DIFF_BITS'(comp_of(b, 0)) - DIFF_BITS'(comp_of(a, 0));
      d.y = DIFF_BITS'(comp_of(b, 1)) - DIFF_BITS'(comp_of(a, 1));
      d.z = DIFF_BITS'(comp_of(b, 2)) - DIFF_BITS'(comp_of(a, 2));
      return d;
   endfunction

endpackage

// ===== rtl/lvm_front.sv =====
// Front end: takes requests, forms pair differences and the three curl components.
module lvm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_left_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_right_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_down_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_up_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_prev_slice_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_next_slice_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_prev_depth_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0] req_next_depth_vector,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_plane_mode,
   output logic                         curl_valid,
   output lvm_pkg::curl_type            curl_item,
   input  logic                         curl_full
);
   import lvm_pkg::*;

   plane_mode_type mode_ff, mode_in;
   logic           front_valid_ff, front_valid_in;
   curl_type       curl_ff, curl_in, curl_new;
   diff_type       h_diff, v_diff, s_diff, d_diff;
   diff_type       dx, dy, dz;
   logic           accept;

   assign req_full   = front_valid_ff & curl_full;
   assign accept     = req_push & ~req_full;
   assign curl_valid = front_valid_ff;
   assign curl_item  = curl_ff;

   // pair differences
   assign h_diff = diff_of(req_left_vector, req_right_vector);
   assign v_diff = diff_of(req_down_vector, req_up_vector);
   assign s_diff = diff_of(req_prev_slice_vector, req_next_slice_vector);
   assign d_diff = diff_of(req_prev_depth_vector, req_next_depth_vector);

   // map pairs onto d/dx, d/dy, d/dz by plane mode
   always_comb begin
      case (mode_ff)
         MODE_XY: begin
            dx = h_diff; dy = v_diff; dz = s_diff;
         end
         MODE_XZ: begin
            dx = h_diff; dy = s_diff; dz = v_diff;
         end
         MODE_YZ: begin
            dx = s_diff; dy = v_diff; dz = h_diff;
         end
         MODE_ROT: begin
            dx = s_diff; dy = v_diff; dz = d_diff;
         end
         default: begin
            dx = h_diff; dy = v_diff; dz = s_diff;
         end
      endcase
   end

   // curl components, negated; the sign drops out in the squared magnitude
   always_comb begin
      curl_new.c1 = CURL_BITS'(dz.y) - CURL_BITS'(dy.z);
      curl_new.c2 = CURL_BITS'(dx.z) - CURL_BITS'(dz.x);
      curl_new.c3 = CURL_BITS'(dy.x) - CURL_BITS'(dx.y);
   end

   // stage register and mode register next values
   always_comb begin
      front_valid_in = accept | (front_valid_ff & curl_full);
      curl_in        = accept ? curl_new : curl_ff;
      mode_in        = csr_write ? plane_mode_type'(csr_plane_mode) : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         mode_ff        <= MODE_XY;
      end else begin
         front_valid_ff <= front_valid_in;
         mode_ff        <= mode_in;
      end
      curl_ff <= curl_in;
   end

endmodule

// ===== rtl/lvm_mid_queue.sv =====
// Short queue of curl items between front and back end.
module lvm_mid_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lvm_pkg::curl_type push_item,
   output logic              full,
   output logic              pop_valid,
   output lvm_pkg::curl_type pop_item,
   input  logic              pop_take
);
   import lvm_pkg::*;

   curl_type            entry_ff [MQ_DEPTH];
   logic [MQ_PTR-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [MQ_PTR-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [MQ_PTR:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == (MQ_PTR+1)'(MQ_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop_take & pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (MQ_PTR+1)'(do_push) - (MQ_PTR+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/lvm_back.sv =====
// Back end: squared magnitude, pipelined log2, ln scaling, saturation and result queue.
module lvm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  lvm_pkg::curl_type                   in_item,
   output logic                                in_take,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [lvm_pkg::OUT_BITS-1:0] rsp_log_vorticity,
   output logic                                rsp_zero_magnitude
);
   import lvm_pkg::*;

   // credit: requests in flight plus results waiting
   logic [RQ_PTR:0] credit_ff, credit_in;
   logic            pop_acc;

   // square stage
   logic               sq_valid_ff;
   logic [SQ_BITS-1:0] sq1_ff, sq2_ff, sq3_ff;
   // sum stage
   logic                sum_valid_ff;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   // top bit stage
   logic                tb_valid_ff, tb_zero_ff;
   logic [SUM_BITS-1:0] tb_sum_ff;
   logic [EXP_BITS-1:0] tb_exp_ff, tb_exp_in;
   // normalize and log2 iteration stages, index 0 is the normalized mantissa
   logic                 it_valid_ff [LOG_FRAC+1];
   logic                 it_zero_ff  [LOG_FRAC+1];
   logic [EXP_BITS-1:0]  it_exp_ff   [LOG_FRAC+1];
   logic [MANT_BITS-1:0] it_mant_ff  [LOG_FRAC+1];
   logic [MANT_BITS-1:0] it_mant_in  [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]  it_frac_ff  [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]  it_frac_in  [LOG_FRAC+1];
   logic [2*MANT_BITS-1:0] it_sq     [LOG_FRAC+1];
   logic [MANT_BITS:0]     it_t      [LOG_FRAC+1];
   logic [NORM_BITS-1:0]   norm_word;
   logic [SHIFT_BITS-1:0]  norm_shift;
   // ln scaling stage
   logic                        prod_valid_ff, prod_zero_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [LOG_BITS-1:0]  log2_val;
   logic [LOG_INT_BITS-1:0]     log2_int;
   // rounding and saturation
   logic                 round_neg;
   logic [PROD_BITS:0]   abs_prod, round_sum;
   logic [MAG_BITS-1:0]  round_mag;
   result_type           result_new;
   // result queue
   result_type          rq_ff [RQ_DEPTH];
   logic [RQ_PTR-1:0]   rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [RQ_PTR:0]     rq_count_ff, rq_count_in;

   // issue control
   assign pop_acc = rsp_pop & ~rsp_empty;
   assign in_take = in_valid & (credit_ff != (RQ_PTR+1)'(RQ_DEPTH));

   always_comb begin
      credit_in = credit_ff + (RQ_PTR+1)'(in_take) - (RQ_PTR+1)'(pop_acc);
   end

   // sum of squares
   always_comb begin
      sum_in = SUM_BITS'(sq1_ff) + SUM_BITS'(sq2_ff) + SUM_BITS'(sq3_ff);
   end

   // position of the top set bit
   always_comb begin
      tb_exp_in = '0;
      for (int i = 0; i < SUM_BITS; i++) begin
         if (sum_ff[i]) begin
            tb_exp_in = EXP_BITS'(i);
         end
      end
   end

   // normalize so the top bit lands at mantissa bit 31, then
   // one fraction bit per stage: square, renormalize
   always_comb begin
      norm_shift = SHIFT_BITS'(NORM_BITS - 1) - SHIFT_BITS'(tb_exp_ff);
      norm_word  = NORM_BITS'(tb_sum_ff) << norm_shift;
      it_mant_in[0] = norm_word[NORM_BITS-1 -: MANT_BITS];
      it_frac_in[0] = '0;
      it_sq[0]      = '0;
      it_t[0]       = '0;
      for (int k = 1; k <= LOG_FRAC; k++) begin
         it_sq[k] = it_mant_ff[k-1] * it_mant_ff[k-1];
         it_t[k]  = it_sq[k][2*MANT_BITS-1 -: MANT_BITS+1];
         if (it_t[k][MANT_BITS]) begin
            it_mant_in[k] = it_t[k][MANT_BITS:1];
            it_frac_in[k] = {it_frac_ff[k-1][LOG_FRAC-2:0], 1'b1};
         end else begin
            it_mant_in[k] = it_t[k][MANT_BITS-1:0];
            it_frac_in[k] = {it_frac_ff[k-1][LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   // log2 to natural log
   always_comb begin
      log2_int = LOG_INT_BITS'(it_exp_ff[LOG_FRAC]) - LOG_INT_BITS'(LOG_OFFSET);
      log2_val = {log2_int, it_frac_ff[LOG_FRAC]};
      prod_in  = PROD_BITS'(log2_val) * $signed(PROD_BITS'(LN2_Q30));
   end

   // round half away from zero, saturate
   always_comb begin
      round_neg = prod_ff[PROD_BITS-1];
      abs_prod  = round_neg ? (PROD_BITS+1)'(-prod_ff) : (PROD_BITS+1)'(prod_ff);
      round_sum = abs_prod + ((PROD_BITS+1)'(1) << (ROUND_SHIFT - 1));
      round_mag = round_sum[PROD_BITS -: MAG_BITS];
      result_new.zero_magnitude = prod_zero_ff;
      if (prod_zero_ff) begin
         result_new.log_vorticity = OUT_MIN;
      end else if (!round_neg) begin
         if (round_mag > MAG_BITS'(OUT_MAX)) begin
            result_new.log_vorticity = OUT_MAX;
         end else begin
            result_new.log_vorticity = OUT_BITS'(round_mag);
         end
      end else begin
         if (round_mag > MAG_BITS'({1'b1, {(OUT_BITS-1){1'b0}}})) begin
            result_new.log_vorticity = OUT_MIN;
         end else begin
            result_new.log_vorticity = -OUT_BITS'(round_mag);
         end
      end
   end

   // result queue pointers
   always_comb begin
      rq_wr_in    = prod_valid_ff ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in    = pop_acc ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_count_in = rq_count_ff + (RQ_PTR+1)'(prod_valid_ff) - (RQ_PTR+1)'(pop_acc);
   end

   assign rsp_empty          = (rq_count_ff == '0);
   assign rsp_log_vorticity  = rq_ff[rq_rd_ff].log_vorticity;
   assign rsp_zero_magnitude = rq_ff[rq_rd_ff].zero_magnitude;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff     <= '0;
         sq_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
         tb_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rq_wr_ff      <= '0;
         rq_rd_ff      <= '0;
         rq_count_ff   <= '0;
         for (int k = 0; k <= LOG_FRAC; k++) begin
            it_valid_ff[k] <= 1'b0;
         end
      end else begin
         credit_ff      <= credit_in;
         sq_valid_ff    <= in_take;
         sum_valid_ff   <= sq_valid_ff;
         tb_valid_ff    <= sum_valid_ff;
         it_valid_ff[0] <= tb_valid_ff;
         for (int k = 1; k <= LOG_FRAC; k++) begin
            it_valid_ff[k] <= it_valid_ff[k-1];
         end
         prod_valid_ff  <= it_valid_ff[LOG_FRAC];
         rq_wr_ff       <= rq_wr_in;
         rq_rd_ff       <= rq_rd_in;
         rq_count_ff    <= rq_count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sq1_ff <= SQ_BITS'(in_item.c1 * in_item.c1);
      sq2_ff <= SQ_BITS'(in_item.c2 * in_item.c2);
      sq3_ff <= SQ_BITS'(in_item.c3 * in_item.c3);
      sum_ff <= sum_in;
      tb_sum_ff  <= sum_ff;
      tb_exp_ff  <= tb_exp_in;
      tb_zero_ff <= (sum_ff == '0);
      it_mant_ff[0] <= it_mant_in[0];
      it_frac_ff[0] <= it_frac_in[0];
      it_exp_ff[0]  <= tb_exp_ff;
      it_zero_ff[0] <= tb_zero_ff;
      for (int k = 1; k <= LOG_FRAC; k++) begin
         it_mant_ff[k] <= it_mant_in[k];
         it_frac_ff[k] <= it_frac_in[k];
         it_exp_ff[k]  <= it_exp_ff[k-1];
         it_zero_ff[k] <= it_zero_ff[k-1];
      end
      prod_ff      <= prod_in;
      prod_zero_ff <= it_zero_ff[LOG_FRAC];
      if (prod_valid_ff) begin
         rq_ff[rq_wr_ff] <= result_new;
      end
   end

endmodule

// ===== rtl/log_vorticity_magnitude_unit.sv =====
// Log vorticity magnitude unit: queue-style request/response top level.
// Requests pass the front stage, curl queue and back-end pipeline to the
// response queue. Throughput: one request per cycle while credits remain, set by
// the fully pipelined back end (one log2 squaring multiplier per fraction bit).
// The 32-entry response queue and its credit count bound the requests in flight.
// Synchronous active-high reset empties all queues and sets plane mode to XY.
module log_vorticity_magnitude_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_left_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_right_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_down_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_up_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_prev_slice_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_next_slice_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_prev_depth_vector,
   input  logic [lvm_pkg::VEC_BITS-1:0]        req_next_depth_vector,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [lvm_pkg::OUT_BITS-1:0] rsp_log_vorticity,
   output logic                                rsp_zero_magnitude,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_plane_mode
);
   import lvm_pkg::*;

   logic     front_valid, mid_full;
   curl_type front_item;
   logic     mid_valid, mid_take;
   curl_type mid_item;

   // register port never stalls
   assign csr_ready = 1'b1;

   lvm_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_left_vector       (req_left_vector),
      .req_right_vector      (req_right_vector),
      .req_down_vector       (req_down_vector),
      .req_up_vector         (req_up_vector),
      .req_prev_slice_vector (req_prev_slice_vector),
      .req_next_slice_vector (req_next_slice_vector),
      .req_prev_depth_vector (req_prev_depth_vector),
      .req_next_depth_vector (req_next_depth_vector),
      .csr_write             (csr_valid & csr_ready),
      .csr_plane_mode        (csr_plane_mode),
      .curl_valid            (front_valid),
      .curl_item             (front_item),
      .curl_full             (mid_full)
   );

   lvm_mid_queue u_mid_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .full       (mid_full),
      .pop_valid  (mid_valid),
      .pop_item   (mid_item),
      .pop_take   (mid_take)
   );

   lvm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (mid_valid),
      .in_item            (mid_item),
      .in_take            (mid_take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_log_vorticity  (rsp_log_vorticity),
      .rsp_zero_magnitude (rsp_zero_magnitude)
   );

endmodule
